// ===== hdl/escape_sequence_decoder_defines.svh =====
// Assertion macros shared by the escape sequence decoder RTL.
`ifndef ESCAPE_SEQUENCE_DECODER_DEFINES_SVH
`define ESCAPE_SEQUENCE_DECODER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define ESD_ASSERT_SAME(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define ESD_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/esd_pkg.sv =====
// Types and constants for the escape sequence decoder.
`default_nettype none

package esd_pkg;

    typedef enum logic [4:0] {
        MODE_NORMAL = 5'b00001,
        MODE_ESC    = 5'b00010,
        MODE_OCT    = 5'b00100,
        MODE_HEX    = 5'b01000,
        MODE_CARET  = 5'b10000
    } mode_t;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_STOP = 1'b1;

    localparam logic [1:0] STOP_NUL    = 2'd0;
    localparam logic [1:0] STOP_COLON  = 2'd1;
    localparam logic [1:0] STOP_EQUALS = 2'd2;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_EQUALS = 8'h3D;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_TILDE  = 8'h7E;
    localparam logic [7:0] CH_LOW_X  = 8'h78;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_SEVEN  = 8'h37;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_LOW_A  = 8'h61;
    localparam logic [7:0] CH_LOW_F  = 8'h66;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_F   = 8'h46;
    localparam logic [7:0] CH_DEL    = 8'd127;
    localparam logic [7:0] CARET_MASK = 8'o37;

    localparam int MAX_RESULTS = 2;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef logic [1:0] rcount_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] out_byte;
        logic [1:0] stop_reason;
        logic       last;
    } result_t;

    typedef struct packed {
        rcount_t          n;
        result_t [1:0]    res;
    } push_t;

endpackage

`default_nettype wire

// ===== hdl/esd_if.sv =====
// Valid/ready channel interfaces for decoder input and result items.
`default_nettype none

interface esd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       stop_on_equals;

    modport source (output valid, output in_byte, output stop_on_equals, input ready);
    modport sink (input valid, input in_byte, input stop_on_equals, output ready);
endinterface

interface esd_out_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] out_byte;
    logic [1:0] stop_reason;
    logic       last;

    modport source (output valid, output kind, output out_byte, output stop_reason,
                    output last, input ready);
    modport sink (input valid, input kind, input out_byte, input stop_reason,
                  input last, output ready);
endinterface

`default_nettype wire

// ===== hdl/esd_decode.sv =====
// Per-character escape decode: next mode, next value and up to two results.
`default_nettype none

module esd_decode (
    input  wire esd_pkg::mode_t mode,
    input  wire logic [7:0]     acc,
    input  wire logic [7:0]     c,
    input  wire logic           eq,
    output esd_pkg::mode_t      mode_next,
    output logic [7:0]          acc_next,
    output esd_pkg::push_t      push
);

    function automatic logic [7:0] letter_escape(input logic [7:0] ch);
        logic [7:0] v;
        begin
            case (ch)
                8'h61:   v = 8'd7;    // a
                8'h62:   v = 8'd8;    // b
                8'h65:   v = 8'd27;   // e
                8'h66:   v = 8'd12;   // f
                8'h6E:   v = 8'h0a;   // n
                8'h72:   v = 8'd13;   // r
                8'h74:   v = 8'd9;    // t
                8'h76:   v = 8'd11;   // v
                8'h3F:   v = 8'd127;  // ?
                8'h5F:   v = 8'd32;   // _
                default: v = ch;
            endcase
            return v;
        end
    endfunction

    function automatic esd_pkg::result_t byte_res(input logic [7:0] b);
        esd_pkg::result_t r;
        begin
            r.kind        = esd_pkg::KIND_BYTE;
            r.out_byte    = b;
            r.stop_reason = esd_pkg::STOP_NUL;
            r.last        = 1'b0;
            return r;
        end
    endfunction

    function automatic esd_pkg::result_t stop_res(input logic [1:0] why);
        esd_pkg::result_t r;
        begin
            r.kind        = esd_pkg::KIND_STOP;
            r.out_byte    = 8'h00;
            r.stop_reason = why;
            r.last        = 1'b0;
            return r;
        end
    endfunction

    logic               is_oct;
    logic               is_dec;
    logic               is_hex;
    logic [3:0]         hex_val;
    logic               p_has;
    esd_pkg::mode_t     p_mode;
    esd_pkg::result_t   p_res;
    esd_pkg::result_t   r0;
    esd_pkg::result_t   r1;
    esd_pkg::rcount_t   n;
    esd_pkg::rcount_t   p_n2;

    assign is_oct = (c >= esd_pkg::CH_ZERO) && (c <= esd_pkg::CH_SEVEN);
    assign is_dec = (c >= esd_pkg::CH_ZERO) && (c <= esd_pkg::CH_NINE);
    assign is_hex = is_dec
                 || ((c >= esd_pkg::CH_LOW_A) && (c <= esd_pkg::CH_LOW_F))
                 || ((c >= esd_pkg::CH_UP_A) && (c <= esd_pkg::CH_UP_F));
    // letters a-f / A-F have low nibble 1..6
    assign hex_val = is_dec ? c[3:0] : c[3:0] + 4'd9;

    // plain-character handling, also used after a flushed run or caret
    always_comb
    begin
        p_has  = 1'b1;
        p_mode = esd_pkg::MODE_NORMAL;
        p_res  = byte_res(c);
        if (c == esd_pkg::CH_NUL)
        begin
            p_res = stop_res(esd_pkg::STOP_NUL);
        end
        else if (c == esd_pkg::CH_COLON)
        begin
            p_res = stop_res(esd_pkg::STOP_COLON);
        end
        else if (eq && (c == esd_pkg::CH_EQUALS))
        begin
            p_res = stop_res(esd_pkg::STOP_EQUALS);
        end
        else if (c == esd_pkg::CH_BSLASH)
        begin
            p_has  = 1'b0;
            p_mode = esd_pkg::MODE_ESC;
        end
        else if (c == esd_pkg::CH_CARET)
        begin
            p_has  = 1'b0;
            p_mode = esd_pkg::MODE_CARET;
        end
    end

    assign p_n2 = esd_pkg::rcount_t'({1'b0, p_has} + 2'd1);

    always_comb
    begin
        mode_next = mode;
        acc_next  = acc;
        n         = 2'd0;
        r0        = p_res;
        r1        = p_res;
        unique case (mode)
            esd_pkg::MODE_ESC:
            begin
                if (c == esd_pkg::CH_NUL)
                begin
                    n         = 2'd1;
                    r0        = stop_res(esd_pkg::STOP_NUL);
                    mode_next = esd_pkg::MODE_NORMAL;
                    acc_next  = 8'h00;
                end
                else if (is_oct)
                begin
                    mode_next = esd_pkg::MODE_OCT;
                    acc_next  = {5'b0, c[2:0]};
                end
                else if (c == esd_pkg::CH_LOW_X)
                begin
                    mode_next = esd_pkg::MODE_HEX;
                    acc_next  = 8'h00;
                end
                else
                begin
                    n         = 2'd1;
                    r0        = byte_res(letter_escape(c));
                    mode_next = esd_pkg::MODE_NORMAL;
                end
            end
            esd_pkg::MODE_OCT:
            begin
                if (is_oct)
                begin
                    acc_next = {acc[4:0], c[2:0]};
                end
                else
                begin
                    n         = p_n2;
                    r0        = byte_res(acc);
                    mode_next = p_mode;
                    acc_next  = 8'h00;
                end
            end
            esd_pkg::MODE_HEX:
            begin
                if (is_hex)
                begin
                    acc_next = {acc[3:0], hex_val};
                end
                else
                begin
                    n         = p_n2;
                    r0        = byte_res(acc);
                    mode_next = p_mode;
                    acc_next  = 8'h00;
                end
            end
            esd_pkg::MODE_CARET:
            begin
                if (c == esd_pkg::CH_QMARK)
                begin
                    n         = 2'd1;
                    r0        = byte_res(esd_pkg::CH_DEL);
                    mode_next = esd_pkg::MODE_NORMAL;
                end
                else if ((c >= esd_pkg::CH_AT) && (c <= esd_pkg::CH_TILDE))
                begin
                    n         = 2'd1;
                    r0        = byte_res(c & esd_pkg::CARET_MASK);
                    mode_next = esd_pkg::MODE_NORMAL;
                end
                else
                begin
                    // literal caret, then the character as plain text
                    n         = p_n2;
                    r0        = byte_res(esd_pkg::CH_CARET);
                    mode_next = p_mode;
                    acc_next  = 8'h00;
                end
            end
            default:
            begin
                n         = {1'b0, p_has};
                r0        = p_res;
                mode_next = p_mode;
                acc_next  = 8'h00;
            end
        endcase

        if (n == 2'd1)
        begin
            r0.last = 1'b1;
        end
        if (n == 2'd2)
        begin
            r1.last = 1'b1;
        end
    end

    assign push.n      = n;
    assign push.res[0] = r0;
    assign push.res[1] = r1;

endmodule

`default_nettype wire

// ===== hdl/esd_out_queue.sv =====
// Result queue: takes up to two results per cycle, hands out one per cycle while rsp is ready.
`default_nettype none

`include "escape_sequence_decoder_defines.svh"

module esd_out_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire esd_pkg::push_t push,
    output logic                space,
    esd_out_if.source           rsp
);

    esd_pkg::result_t             q_reg [esd_pkg::QUEUE_DEPTH];
    logic [esd_pkg::QPTR_W-1:0]   head_reg;
    logic [esd_pkg::QPTR_W-1:0]   head_next;
    logic [esd_pkg::QPTR_W-1:0]   tail_reg;
    logic [esd_pkg::QPTR_W-1:0]   tail_next;
    logic [esd_pkg::QPTR_W-1:0]   tail_plus1;
    logic [esd_pkg::QCNT_W-1:0]   cnt_reg;
    logic [esd_pkg::QCNT_W-1:0]   cnt_next;
    logic                         pop;

    assign space      = cnt_reg <= esd_pkg::QCNT_W'(esd_pkg::QUEUE_DEPTH - esd_pkg::MAX_RESULTS);
    assign pop        = rsp.valid && rsp.ready;
    assign tail_plus1 = esd_pkg::QPTR_W'(tail_reg + 1'b1);

    assign rsp.valid       = cnt_reg != '0;
    assign rsp.kind        = q_reg[head_reg].kind;
    assign rsp.out_byte    = q_reg[head_reg].out_byte;
    assign rsp.stop_reason = q_reg[head_reg].stop_reason;
    assign rsp.last        = q_reg[head_reg].last;

    always_comb
    begin
        head_next = pop ? esd_pkg::QPTR_W'(head_reg + 1'b1) : head_reg;
        tail_next = esd_pkg::QPTR_W'(tail_reg + esd_pkg::QPTR_W'(push.n));
        cnt_next  = esd_pkg::QCNT_W'(cnt_reg + esd_pkg::QCNT_W'(push.n)
                                     - esd_pkg::QCNT_W'(pop));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.n != 2'd0)
        begin
            q_reg[tail_reg] <= push.res[0];
        end
        if (push.n == 2'd2)
        begin
            q_reg[tail_plus1] <= push.res[1];
        end
    end

    `ESD_ASSERT_SAME(a_cnt_bound, clk, rst_n, 1'b1,
        cnt_reg <= esd_pkg::QCNT_W'(esd_pkg::QUEUE_DEPTH), "result queue overfilled")
    `ESD_ASSERT_SAME(a_push_has_space, clk, rst_n, push.n != 2'd0, space,
        "results pushed without room")
    `ESD_ASSERT_NEXT(a_hold_on_stall, clk, rst_n, rsp.valid && !rsp.ready,
        $stable(head_reg) && rsp.valid, "queue head moved while stalled")

endmodule

`default_nettype wire

// ===== hdl/escape_sequence_decoder.sv =====
// A result is queued when the item that causes it is taken and is offered on rsp at the earliest in the cycle after.
// Throughput: one item per cycle while the result queue has room; an item with two results holds two queue slots,
// so the rate then follows the single result port (one result per cycle while rsp is ready).
// The decode is a single mode/value register update per item; input is taken while
// the four-entry result queue has room for two results.
// Reset (rst_n low, async): normal mode, value zero, result queue empty.
`default_nettype none

`include "escape_sequence_decoder_defines.svh"

module escape_sequence_decoder (
    input  wire logic clk,
    input  wire logic rst_n,
    esd_in_if.sink    req,
    esd_out_if.source rsp
);

    esd_pkg::mode_t   mode_reg;
    esd_pkg::mode_t   mode_next;
    logic [7:0]       acc_reg;
    logic [7:0]       acc_next;
    esd_pkg::push_t   dec_push;
    esd_pkg::push_t   q_push;
    logic             space;
    logic             accept;

    assign req.ready = space;
    assign accept    = req.valid && req.ready;

    esd_decode u_decode (
        .mode      (mode_reg),
        .acc       (acc_reg),
        .c         (req.in_byte),
        .eq        (req.stop_on_equals),
        .mode_next (mode_next),
        .acc_next  (acc_next),
        .push      (dec_push)
    );

    always_comb
    begin
        q_push   = dec_push;
        q_push.n = accept ? dec_push.n : 2'd0;
    end

    esd_out_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .space (space),
        .rsp   (rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= esd_pkg::MODE_NORMAL;
            acc_reg  <= 8'h00;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            acc_reg  <= acc_next;
        end
    end

    `ESD_ASSERT_SAME(a_two_last, clk, rst_n, q_push.n == 2'd2,
        !q_push.res[0].last && q_push.res[1].last, "wrong last flag on result pair")
    `ESD_ASSERT_NEXT(a_stop_clears, clk, rst_n,
        (q_push.n == 2'd1 && q_push.res[0].kind == esd_pkg::KIND_STOP)
        || (q_push.n == 2'd2 && q_push.res[1].kind == esd_pkg::KIND_STOP),
        mode_reg == esd_pkg::MODE_NORMAL && acc_reg == 8'h00, "field end left state")
    `ESD_ASSERT_NEXT(a_idle_hold, clk, rst_n, !accept,
        $stable(mode_reg) && $stable(acc_reg), "state changed without an item")

endmodule

`default_nettype wire

// ===== tb/sv/tb_escape_sequence_decoder.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the escape sequence decoder: directed and random character streams.

module tb_escape_sequence_decoder;

    localparam logic [1:0] REASON_NONE = esd_pkg::STOP_NUL;   // stop_reason on byte results

    // Tracks decoder state per accepted character and holds the results still owed.
    class escape_tracker;
        esd_pkg::mode_t    mode;
        logic [7:0]        acc;
        esd_pkg::result_t  step_out[$];
        esd_pkg::result_t  expected_out[$];
        int unsigned       errors;
        int unsigned       n_chars;
        int unsigned       n_results;
        int unsigned       n_stops;

        function new();
            mode = esd_pkg::MODE_NORMAL;
            acc = 8'd0;
            errors = 0;
            n_chars = 0;
            n_results = 0;
            n_stops = 0;
        endfunction

        function void emit(logic kind, logic [7:0] b, logic [1:0] why);
            esd_pkg::result_t r;
            r.kind = kind;
            r.out_byte = b;
            r.stop_reason = why;
            r.last = 1'b0;
            step_out.push_back(r);
        endfunction

        function void end_field(logic [1:0] why);
            emit(esd_pkg::KIND_STOP, 8'd0, why);
            mode = esd_pkg::MODE_NORMAL;
            acc = 8'd0;
        endfunction

        function logic [7:0] letter_value(logic [7:0] c);
            case (c)
                "a": return 8'd7;
                "b": return 8'd8;
                "e": return 8'd27;
                "f": return 8'd12;
                "n": return 8'd10;
                "r": return 8'd13;
                "t": return 8'd9;
                "v": return 8'd11;
                esd_pkg::CH_QMARK: return esd_pkg::CH_DEL;
                "_": return 8'd32;
                default: return c;
            endcase
        endfunction

        function int hex_digit(logic [7:0] c);
            if (c >= esd_pkg::CH_ZERO && c <= esd_pkg::CH_NINE)
                return int'(c - esd_pkg::CH_ZERO);
            if (c >= esd_pkg::CH_LOW_A && c <= esd_pkg::CH_LOW_F)
                return int'(c - esd_pkg::CH_LOW_A) + 10;
            if (c >= esd_pkg::CH_UP_A && c <= esd_pkg::CH_UP_F)
                return int'(c - esd_pkg::CH_UP_A) + 10;
            return -1;
        endfunction

        function void plain_char(logic [7:0] c, logic eq);
            mode = esd_pkg::MODE_NORMAL;
            acc = 8'd0;
            if (c == esd_pkg::CH_NUL)
                end_field(esd_pkg::STOP_NUL);
            else if (c == esd_pkg::CH_COLON)
                end_field(esd_pkg::STOP_COLON);
            else if (eq && c == esd_pkg::CH_EQUALS)
                end_field(esd_pkg::STOP_EQUALS);
            else if (c == esd_pkg::CH_BSLASH)
                mode = esd_pkg::MODE_ESC;
            else if (c == esd_pkg::CH_CARET)
                mode = esd_pkg::MODE_CARET;
            else
                emit(esd_pkg::KIND_BYTE, c, REASON_NONE);
        endfunction

        // Called for every accepted input item.
        function void feed_char(logic [7:0] c, logic eq);
            int h;
            step_out.delete();
            n_chars++;
            case (mode)
                esd_pkg::MODE_ESC:
                begin
                    if (c == esd_pkg::CH_NUL)
                        end_field(esd_pkg::STOP_NUL);
                    else if (c >= esd_pkg::CH_ZERO && c <= esd_pkg::CH_SEVEN)
                    begin
                        mode = esd_pkg::MODE_OCT;
                        acc = c - esd_pkg::CH_ZERO;
                    end
                    else if (c == esd_pkg::CH_LOW_X)
                    begin
                        mode = esd_pkg::MODE_HEX;
                        acc = 8'd0;
                    end
                    else
                    begin
                        emit(esd_pkg::KIND_BYTE, letter_value(c), REASON_NONE);
                        mode = esd_pkg::MODE_NORMAL;
                    end
                end
                esd_pkg::MODE_OCT:
                begin
                    if (c >= esd_pkg::CH_ZERO && c <= esd_pkg::CH_SEVEN)
                        acc = (acc << 3) + (c - esd_pkg::CH_ZERO);
                    else
                    begin
                        emit(esd_pkg::KIND_BYTE, acc, REASON_NONE);
                        plain_char(c, eq);
                    end
                end
                esd_pkg::MODE_HEX:
                begin
                    h = hex_digit(c);
                    if (h >= 0)
                        acc = (acc << 4) + 8'(h);
                    else
                    begin
                        emit(esd_pkg::KIND_BYTE, acc, REASON_NONE);
                        plain_char(c, eq);
                    end
                end
                esd_pkg::MODE_CARET:
                begin
                    if (c == esd_pkg::CH_QMARK)
                    begin
                        emit(esd_pkg::KIND_BYTE, esd_pkg::CH_DEL, REASON_NONE);
                        mode = esd_pkg::MODE_NORMAL;
                    end
                    else if (c >= esd_pkg::CH_AT && c <= esd_pkg::CH_TILDE)
                    begin
                        emit(esd_pkg::KIND_BYTE, c & esd_pkg::CARET_MASK, REASON_NONE);
                        mode = esd_pkg::MODE_NORMAL;
                    end
                    else
                    begin
                        // not a caret pair: literal caret, then the char again
                        emit(esd_pkg::KIND_BYTE, esd_pkg::CH_CARET, REASON_NONE);
                        plain_char(c, eq);
                    end
                end
                default:
                    plain_char(c, eq);
            endcase
            if (step_out.size() > 0)
                step_out[step_out.size() - 1].last = 1'b1;
            foreach (step_out[i])
                expected_out.push_back(step_out[i]);
        endfunction

        task report(string what);
            $display("mismatch @%0t: %s", $realtime, what);
            errors++;
        endtask

        task check_result(esd_pkg::result_t got);
            esd_pkg::result_t want;
            if (expected_out.size() == 0)
            begin
                report($sformatf("unexpected result kind=%0b byte=%02h", got.kind,
                                 got.out_byte));
                return;
            end
            want = expected_out.pop_front();
            n_results++;
            if (want.kind == esd_pkg::KIND_STOP)
                n_stops++;
            if (got.kind !== want.kind)
                report($sformatf("kind %0b, want %0b", got.kind, want.kind));
            if (got.out_byte !== want.out_byte)
                report($sformatf("out_byte %02h, want %02h", got.out_byte, want.out_byte));
            if (got.stop_reason !== want.stop_reason)
                report($sformatf("stop_reason %0d, want %0d", got.stop_reason,
                                 want.stop_reason));
            if (got.last !== want.last)
                report($sformatf("last %0b, want %0b", got.last, want.last));
        endtask
    endclass

    logic clk;
    logic rst_n;

    esd_in_if  req_ch ();
    esd_out_if rsp_ch ();

    escape_tracker sb = new();

    int idle_pct;
    int stall_pct;
    int holdoff_cycles;
    int sent;

    escape_sequence_decoder uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #400000;
        $display("tb: failure");
        $finish;
    end

    // Result side: random stalls, plus a counted hold-off when requested.
    initial
    begin
        esd_pkg::result_t got;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (holdoff_cycles > 0)
            begin
                rsp_ch.ready <= 1'b0;
                holdoff_cycles--;
            end
            else
                rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
            @(posedge clk);
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                got.kind = rsp_ch.kind;
                got.out_byte = rsp_ch.out_byte;
                got.stop_reason = rsp_ch.stop_reason;
                got.last = rsp_ch.last;
                sb.check_result(got);
            end
        end
    end

    function automatic logic coin();
        return 1'($urandom_range(0, 1));
    endfunction

    task automatic send_char(input logic [7:0] c, input logic eq);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            @(negedge clk);
            req_ch.valid <= 1'b0;
            req_ch.in_byte <= 8'($urandom);
            @(posedge clk);
        end
        @(negedge clk);
        req_ch.valid <= 1'b1;
        req_ch.in_byte <= c;
        req_ch.stop_on_equals <= eq;
        do
            @(posedge clk);
        while (!req_ch.ready);
        sb.feed_char(c, eq);
        sent++;
    endtask

    task automatic hold_input_idle();
        @(negedge clk);
        req_ch.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (sb.expected_out.size() != 0)
            @(posedge clk);
    endtask

    // Mostly well-formed escapes with random content, some raw noise.
    task automatic send_token();
        int pick;
        int n;
        string letters;
        string hexd;
        letters = "abefnrtv?_";
        hexd = "0123456789abcdefABCDEF";
        pick = $urandom_range(0, 99);
        if (pick < 20)
            send_char(8'($urandom), coin());
        else if (pick < 30)
            send_char(8'($urandom_range(32, 126)), coin());
        else if (pick < 45)
        begin
            send_char(esd_pkg::CH_BSLASH, coin());
            if (coin())
                send_char(letters[$urandom_range(0, 9)], coin());
            else
                send_char(8'($urandom_range(32, 126)), coin());
        end
        else if (pick < 60)
        begin
            send_char(esd_pkg::CH_BSLASH, coin());
            n = $urandom_range(1, 4);
            repeat (n)
                send_char(esd_pkg::CH_ZERO + 8'($urandom_range(0, 7)), coin());
        end
        else if (pick < 72)
        begin
            send_char(esd_pkg::CH_BSLASH, coin());
            send_char(esd_pkg::CH_LOW_X, coin());
            n = $urandom_range(0, 3);
            repeat (n)
                send_char(hexd[$urandom_range(0, 21)], coin());
        end
        else if (pick < 84)
        begin
            send_char(esd_pkg::CH_CARET, coin());
            case ($urandom_range(0, 2))
                0: send_char(esd_pkg::CH_QMARK, coin());
                1: send_char(8'($urandom_range(64, 126)), coin());
                default: send_char(8'($urandom), coin());
            endcase
        end
        else if (pick < 94)
        begin
            case ($urandom_range(0, 2))
                0: send_char(esd_pkg::CH_NUL, coin());
                1: send_char(esd_pkg::CH_COLON, coin());
                default: send_char(esd_pkg::CH_EQUALS, coin());
            endcase
        end
        else
        begin
            send_char(esd_pkg::CH_BSLASH, coin());
            send_char(8'($urandom), coin());
        end
    endtask

    initial
    begin
        int target;
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.in_byte = 8'd0;
        req_ch.stop_on_equals = 1'b0;
        idle_pct = 0;
        stall_pct = 0;
        holdoff_cycles = 0;
        sent = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_char(8'hFF, 1'b1);
        send_char(esd_pkg::CH_BSLASH, 1'b0);
        send_char("n", 1'b0);
        // octal run that overflows 8 bits, ended by a colon
        send_char(esd_pkg::CH_BSLASH, 1'b0);
        send_char("3", 1'b0);
        send_char("7", 1'b0);
        send_char("7", 1'b0);
        send_char("1", 1'b0);
        send_char(esd_pkg::CH_COLON, 1'b0);
        // hex run with mixed case, ended by an equals that stops
        send_char(esd_pkg::CH_BSLASH, 1'b0);
        send_char(esd_pkg::CH_LOW_X, 1'b0);
        send_char("F", 1'b0);
        send_char("a", 1'b0);
        send_char(esd_pkg::CH_EQUALS, 1'b1);
        // empty hex run flushes zero, then a caret pair
        send_char(esd_pkg::CH_BSLASH, 1'b0);
        send_char(esd_pkg::CH_LOW_X, 1'b0);
        send_char(esd_pkg::CH_CARET, 1'b0);
        send_char(esd_pkg::CH_QMARK, 1'b0);
        send_char(esd_pkg::CH_CARET, 1'b0);
        send_char(esd_pkg::CH_EQUALS, 1'b0);
        send_char(esd_pkg::CH_CARET, 1'b0);
        send_char(esd_pkg::CH_NUL, 1'b1);
        send_char(esd_pkg::CH_BSLASH, 1'b1);
        send_char(esd_pkg::CH_COLON, 1'b1);
        send_char(esd_pkg::CH_BSLASH, 1'b0);
        send_char(esd_pkg::CH_NUL, 1'b0);
        hold_input_idle();
        wait_drained();

        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 88; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 88; end
                default: begin idle_pct = 13; stall_pct = 13; end
            endcase
            target = sent + 130;
            while (sent < target)
                send_token();
            if (p == 0)
            begin
                // result side blocked: queue fills and input backs up
                holdoff_cycles = 60;
                target = sent + 25;
                while (sent < target)
                    send_token();
            end
            hold_input_idle();
            wait_drained();
        end

        repeat (8) @(posedge clk);
        $display("summary: %0d chars in, %0d results checked, %0d of them field ends",
                 sb.n_chars, sb.n_results, sb.n_stops);
        $display("summary: idle mixes none/input/output/both plus one full-queue hold-off");
        if (sb.errors == 0 && sb.expected_out.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
